>>> src/dvfc_pkg.sv
// dvfc_pkg: sizes and shared types for the distinct value frequency counter
// used by dvfc_cell and distinct_value_frequency_counter; no dependencies
`default_nettype none

package dvfc_pkg;

   localparam int MAX_ITEMS  = 64;
   localparam int VALUE_BITS = 64;
   localparam int CNT_W      = $clog2(MAX_ITEMS + 1);

   localparam logic STATE_COLLECT = 1'b0;
   localparam logic STATE_DRAIN   = 1'b1;

   typedef struct packed {
      logic                  update;
      logic                  shift;
      logic [VALUE_BITS-1:0] value;
   } cell_ctrl_type;

endpackage

`default_nettype wire

>>> src/distinct_value_frequency_counter.sv
// distinct_value_frequency_counter: counts occurrences of distinct values in a set.
// Flow: one word per cycle is taken while collecting; the first result shows in the
// cycle after the last word is taken, then one result per cycle while not stalled.
// No word is taken while a set's results drain; collecting resumes after the last result.
// Reset: synchronous; empties the cell chain and clears totals and the overflow flag.
// depends on dvfc_pkg and dvfc_cell
`default_nettype none

module distinct_value_frequency_counter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_value,
   input  wire logic        req_last_item,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_distinct_value,
   output logic [6:0]       rsp_occurrences,
   output logic [6:0]       rsp_set_total,
   output logic             rsp_overflow,
   output logic             rsp_last_result
);
   import dvfc_pkg::*;

   logic                  state_ff, state_in;
   logic [CNT_W-1:0]      items_ff, items_in;
   logic                  dropped_ff, dropped_in;

   logic                  req_take, rsp_take, room;
   logic                  fresh;
   cell_ctrl_type         ctrl;

   logic [MAX_ITEMS-1:0]  vld;
   logic [MAX_ITEMS-1:0]  hit;
   logic [VALUE_BITS-1:0] val [MAX_ITEMS];
   logic [CNT_W-1:0]      cnt [MAX_ITEMS];

   assign req_stall = (state_ff == STATE_DRAIN);
   assign req_take  = req_valid && !req_stall;
   assign room      = (items_ff < CNT_W'(MAX_ITEMS));

   assign rsp_valid       = (state_ff == STATE_DRAIN);
   assign rsp_take        = rsp_valid && !rsp_stall;
   assign rsp_last_result = !vld[1];

   assign ctrl.update = req_take && room;
   assign fresh       = !(|hit);
   assign ctrl.shift  = rsp_take;
   assign ctrl.value  = req_value[VALUE_BITS-1:0];

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      if (i == MAX_ITEMS - 1) begin : g_tail
         dvfc_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .fresh      (fresh),
            .prev_valid (vld[i-1]),
            .next_valid (1'b0),
            .next_value ('0),
            .next_count ('0),
            .valid      (vld[i]),
            .value      (val[i]),
            .count      (cnt[i]),
            .match      (hit[i])
         );
      end else if (i == 0) begin : g_head
         dvfc_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .fresh      (fresh),
            .prev_valid (1'b1),
            .next_valid (vld[i+1]),
            .next_value (val[i+1]),
            .next_count (cnt[i+1]),
            .valid      (vld[i]),
            .value      (val[i]),
            .count      (cnt[i]),
            .match      (hit[i])
         );
      end else begin : g_mid
         dvfc_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .fresh      (fresh),
            .prev_valid (vld[i-1]),
            .next_valid (vld[i+1]),
            .next_value (val[i+1]),
            .next_count (cnt[i+1]),
            .valid      (vld[i]),
            .value      (val[i]),
            .count      (cnt[i]),
            .match      (hit[i])
         );
      end
   end

   assign rsp_distinct_value = 64'(val[0]);
   assign rsp_occurrences    = 7'(cnt[0]);
   assign rsp_set_total      = 7'(items_ff);
   assign rsp_overflow       = dropped_ff;

   always_comb begin
      state_in   = state_ff;
      items_in   = items_ff;
      dropped_in = dropped_ff;
      case (state_ff)
         STATE_COLLECT: begin
            if (req_take) begin
               if (room) begin
                  items_in = items_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_last_item) begin
                  state_in = STATE_DRAIN;
               end
            end
         end
         STATE_DRAIN: begin
            if (rsp_take && rsp_last_result) begin
               state_in   = STATE_COLLECT;
               items_in   = '0;
               dropped_in = 1'b0;
            end
         end
         default: begin
            state_in = STATE_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= STATE_COLLECT;
         items_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         items_ff   <= items_in;
         dropped_ff <= dropped_in;
      end
   end

`ifndef SYNTHESIS
   a_drain_has_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == STATE_DRAIN) |-> vld[0])
      else $error("draining with an empty head cell");

   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      $onehot0(vld ^ (vld >> 1)))
      else $error("valid cells are not a contiguous prefix");

   a_distinct_bound: assert property (@(posedge clock) disable iff (reset)
      $countones(vld) <= int'(items_ff))
      else $error("more distinct entries than accepted words");

   a_drop_flags: assert property (@(posedge clock) disable iff (reset)
      (req_take && !room) |=> dropped_ff)
      else $error("dropped word did not raise overflow");

   a_set_cleared: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_last_result) |=> (items_ff == '0) && (vld == '0))
      else $error("set state not cleared after final result");
`endif

endmodule

`default_nettype wire

>>> src/dvfc_cell.sv
// dvfc_cell: one table entry (value, count, valid) of the counter chain
// depends on dvfc_pkg
`default_nettype none

module dvfc_cell (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire dvfc_pkg::cell_ctrl_type        ctrl,
   input  wire logic                           fresh,
   input  wire logic                           prev_valid,
   input  wire logic                           next_valid,
   input  wire logic [dvfc_pkg::VALUE_BITS-1:0] next_value,
   input  wire logic [dvfc_pkg::CNT_W-1:0]     next_count,
   output logic                                valid,
   output logic [dvfc_pkg::VALUE_BITS-1:0]     value,
   output logic [dvfc_pkg::CNT_W-1:0]          count,
   output logic                                match
);
   import dvfc_pkg::*;

   logic                  valid_ff, valid_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   assign match = valid_ff && (value_ff == ctrl.value);

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      count_in = count_ff;
      if (ctrl.shift) begin
         valid_in = next_valid;
         value_in = next_value;
         count_in = next_count;
      end else if (ctrl.update) begin
         if (match) begin
            count_in = count_ff + CNT_W'(1);
         end else if (!valid_ff && prev_valid && fresh) begin
            valid_in = 1'b1;
            value_in = ctrl.value;
            count_in = CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
      count_ff <= count_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;
   assign count = count_ff;

endmodule

`default_nettype wire

>>> bench/tb.sv
// tb: self-checking bench for distinct_value_frequency_counter, driving sets of words
// and checking every per-value tally against its own frequency table model
// depends on dvfc_pkg and distinct_value_frequency_counter

module tb;
   import dvfc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 200;
   localparam int SETTLE_CYCLES  = 20;
   localparam logic [63:0] VALUE_MASK = 64'((65'd1 << VALUE_BITS) - 65'd1);

   typedef struct packed {
      logic [63:0] value;
      logic [6:0]  occurrences;
      logic [6:0]  total;
      logic        overflow;
      logic        last_result;
   } tally_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_value = '0;
   logic        req_last_item = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_distinct_value;
   logic [6:0]  rsp_occurrences;
   logic [6:0]  rsp_set_total;
   logic        rsp_overflow;
   logic        rsp_last_result;

   // frequency table model
   logic [63:0] known_value [MAX_ITEMS];
   int          known_count [MAX_ITEMS];
   int          distinct_seen = 0;
   int          words_in_set = 0;
   logic        words_dropped = 1'b0;
   tally_t      expected_tallies [$];

   int  mismatches = 0;
   int  words_sent = 0;
   int  sets_sent = 0;
   int  tallies_checked = 0;
   int  idle_cycles = 0;
   bit  no_gaps = 1'b0;
   bit  hold_request = 1'b0;

   distinct_value_frequency_counter dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_value          (req_value),
      .req_last_item      (req_last_item),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_distinct_value (rsp_distinct_value),
      .rsp_occurrences    (rsp_occurrences),
      .rsp_set_total      (rsp_set_total),
      .rsp_overflow       (rsp_overflow),
      .rsp_last_result    (rsp_last_result)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [63:0] random_word();
      logic [63:0] single;
      single = 64'd1 << $urandom_range(0, 63);
      case ($urandom_range(0, 3))
         0: return {$urandom, $urandom};
         1: return single;
         2: return ~single;
         default: return 64'($urandom_range(0, 3));
      endcase
   endfunction

   function automatic void tally_word(logic [63:0] raw, logic last);
      logic [63:0] v;
      bit          hit;
      tally_t      t;
      v = raw & VALUE_MASK;
      if (words_in_set >= MAX_ITEMS) begin
         words_dropped = 1'b1;
      end else begin
         words_in_set++;
         hit = 1'b0;
         for (int i = 0; i < distinct_seen; i++) begin
            if (!hit && known_value[i] == v) begin
               known_count[i]++;
               hit = 1'b1;
            end
         end
         if (!hit) begin
            known_value[distinct_seen] = v;
            known_count[distinct_seen] = 1;
            distinct_seen++;
         end
      end
      if (last) begin
         for (int i = 0; i < distinct_seen; i++) begin
            t.value       = known_value[i];
            t.occurrences = 7'(known_count[i]);
            t.total       = 7'(words_in_set);
            t.overflow    = words_dropped;
            t.last_result = (i == distinct_seen - 1);
            expected_tallies.push_back(t);
         end
         distinct_seen = 0;
         words_in_set  = 0;
         words_dropped = 1'b0;
         sets_sent++;
      end
   endfunction

   // entered and left at a falling edge
   task automatic send_word(input logic [63:0] v, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_value     <= v;
      req_last_item <= last;
      do @(posedge clock); while (req_stall);
      words_sent++;
      tally_word(v, last);
      @(negedge clock);
   endtask

   task automatic send_set(input logic [63:0] words [$]);
      foreach (words[i]) send_word(words[i], i == words.size() - 1);
   endtask

   task automatic wait_for_tallies();
      req_valid <= 1'b0;
      while (expected_tallies.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic test_single_word_sets();
      send_set('{64'h0});
      send_set('{64'hFFFF_FFFF_FFFF_FFFF});
      send_set('{64'h8000_0000_0000_0001});
      send_set('{64'h5555_5555_5555_5555});
      send_set('{64'hAAAA_AAAA_AAAA_AAAA});
   endtask

   task automatic test_repeated_values();
      logic [63:0] a, b, c;
      a = 64'h0123_4567_89AB_CDEF;
      b = 64'h0123_4567_89AB_CDEE;
      c = 64'hFEDC_BA98_7654_3210;
      // repeats, last word a repeat of an earlier one
      send_set('{a, b, a, a, c, b});
      // values one bit apart at both ends
      send_set('{64'h0, 64'h1, 64'h0, 64'h8000_0000_0000_0000, 64'h1, 64'h0});
   endtask

   task automatic test_full_distinct_set();
      logic [63:0] words [$];
      for (int k = 0; k < MAX_ITEMS; k++)
         words.push_back({$urandom, 24'($urandom_range(0, 255)), 8'(k)});
      send_set(words);
   endtask

   task automatic test_overflow_single_value();
      logic [63:0] words [$];
      // one value fills capacity, then new values are dropped, last word dropped too
      for (int k = 0; k < MAX_ITEMS; k++) words.push_back(64'hDEAD_BEEF_0000_0042);
      words.push_back(64'h1);
      words.push_back(64'h2);
      send_set(words);
   endtask

   task automatic test_overflow_mixed();
      logic [63:0] pool [12];
      logic [63:0] words [$];
      foreach (pool[i]) pool[i] = random_word();
      for (int k = 0; k < MAX_ITEMS + 4; k++) words.push_back(pool[$urandom_range(0, 11)]);
      send_set(words);
   endtask

   task automatic test_back_pressure();
      logic [63:0] words [$];
      no_gaps = 1'b1;
      hold_request = 1'b1;
      repeat (4) begin
         words.delete();
         repeat ($urandom_range(8, 12)) words.push_back(64'($urandom_range(0, 5)) << 60);
         send_set(words);
      end
      no_gaps = 1'b0;
   endtask

   task automatic test_random_sets();
      logic [63:0] pool [8];
      logic [63:0] words [$];
      int          first_word;
      first_word = words_sent;
      while (words_sent - first_word < 55) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         foreach (pool[i]) pool[i] = random_word();
         words.delete();
         if ($urandom_range(0, 9) < 8) begin
            repeat ($urandom_range(1, 10)) words.push_back(pool[$urandom_range(0, 7)]);
         end else begin
            repeat ($urandom_range(1, 3)) words.push_back({$urandom, $urandom});
         end
         send_set(words);
      end
      no_gaps = 1'b0;
   endtask

   // receiver stall pattern, with one long hold on request
   initial begin : rsp_stall_gen
      int n;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            n = LONG_HOLD;
         end else begin
            n = pick_gap();
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      tally_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tallies.size() == 0) begin
            $error("unexpected result word: value %0h", rsp_distinct_value);
            mismatches++;
         end else begin
            want = expected_tallies.pop_front();
            check_field("distinct_value", want.value, rsp_distinct_value);
            check_field("occurrences", 64'(want.occurrences), 64'(rsp_occurrences));
            check_field("set_total", 64'(want.total), 64'(rsp_set_total));
            check_field("overflow", 64'(want.overflow), 64'(rsp_overflow));
            check_field("last_result", 64'(want.last_result), 64'(rsp_last_result));
            tallies_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", idle_cycles);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_single_word_sets();
      test_repeated_values();
      test_full_distinct_set();
      test_overflow_single_value();
      wait_for_tallies();
      test_back_pressure();
      wait_for_tallies();
      test_overflow_mixed();
      test_random_sets();
      wait_for_tallies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_tallies.size() != 0) begin
         $error("%0d expected results never arrived", expected_tallies.size());
         mismatches++;
      end
      $display("sent %0d words in %0d sets, checked %0d tallies", words_sent, sets_sent,
               tallies_checked);
      $display("covered full tables, overflow, long receiver hold and random gaps");
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
src/dvfc_pkg.sv
src/dvfc_cell.sv
src/distinct_value_frequency_counter.sv
bench/tb.sv
